### sv/drte_pkg.sv
`timescale 1ns / 1ps
package drte_pkg;

    localparam int ANG_W     = 22;
    localparam int CMD_W     = 3;
    localparam int ALPHA_W   = 16;
    localparam int SENS_W    = 16;
    localparam int THR_W     = 12;
    localparam int THR_SQ_W  = 2 * THR_W;
    localparam int LIM_W     = 21;
    localparam int DB_W      = 16;
    localparam int SETTLE_W  = 16;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 3;
    localparam int EASE_SHIFT = 16;

    typedef logic signed [ANG_W-1:0] t_angle;

    localparam t_angle ANG_MAX = 22'sh1FFFFF;
    localparam t_angle ANG_MIN = -22'sh200000;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 3'd0,
        CMD_MOVE  = 3'd1,
        CMD_END   = 3'd2,
        CMD_RESET = 3'd3,
        CMD_TICK  = 3'd4
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_EASE_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd5;

    localparam logic [ALPHA_W-1:0]  RST_EASE_ALPHA  = 16'd22938;
    localparam logic [SENS_W-1:0]   RST_SENSITIVITY = 16'd22938;
    localparam logic [THR_SQ_W-1:0] RST_ROT_THR_SQ  = 24'd64;
    localparam logic [LIM_W-1:0]    RST_PITCH_LIM   = 21'd91136;
    localparam logic [DB_W-1:0]     RST_DEADBAND    = 16'd51;
    localparam logic [SETTLE_W-1:0] RST_SETTLE      = 16'd102;

    // Result of a move: new targets and whether the travel passed the threshold.
    typedef struct packed {
        t_angle yaw;
        t_angle pitch;
        logic   rotate;
    } t_move_res;

    // Magnitude of an angle; the most negative value maps to 2^21, which still fits.
    function automatic logic [ANG_W-1:0] ang_abs(input t_angle a);
        logic [ANG_W-1:0] m;
        m = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
        return m;
    endfunction

endpackage

### sv/drte_move.sv
`timescale 1ns / 1ps
module drte_move #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 10
) (
    input  logic [COORD_BITS-1:0]         i_x,
    input  logic [COORD_BITS-1:0]         i_y,
    input  logic [COORD_BITS-1:0]         i_start_x,
    input  logic [COORD_BITS-1:0]         i_start_y,
    input  drte_pkg::t_angle              i_anchor_yaw,
    input  drte_pkg::t_angle              i_anchor_pitch,
    input  logic [drte_pkg::SENS_W-1:0]   i_sens,
    input  logic [drte_pkg::LIM_W-1:0]    i_pitch_lim,
    input  logic [drte_pkg::THR_SQ_W-1:0] i_thr_sq,
    output drte_pkg::t_move_res           o_res
);
    import drte_pkg::*;

    localparam int SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int PW    = COORD_BITS + SENS_W + 2;
    localparam int SW    = PW + 1;
    localparam int SQ_W  = 2 * COORD_BITS + 2;
    localparam int DW    = SQ_W + 1;
    localparam int QW    = (DW > THR_SQ_W) ? DW : THR_SQ_W;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        adx, ady;
    logic [SQ_W-1:0]            sq_x, sq_y;
    logic [QW-1:0]              travel_sq;
    logic signed [PW-1:0]       prod_x, prod_y, term_x, term_y;
    logic signed [SW-1:0]       sum_yaw, sum_pitch, lim_pos, lim_neg;

    assign dx = $signed({1'b0, i_x}) - $signed({1'b0, i_start_x});
    assign dy = $signed({1'b0, i_y}) - $signed({1'b0, i_start_y});

    // Arithmetic shift of the signed product floors towards minus infinity.
    assign prod_x = PW'(dx) * PW'($signed({1'b0, i_sens}));
    assign prod_y = PW'(dy) * PW'($signed({1'b0, i_sens}));
    assign term_x = prod_x >>> SHIFT;
    assign term_y = prod_y >>> SHIFT;

    assign sum_yaw   = SW'(term_x) + SW'(i_anchor_yaw);
    assign sum_pitch = SW'(term_y) + SW'(i_anchor_pitch);
    assign lim_pos   = $signed({{(SW-LIM_W){1'b0}}, i_pitch_lim});
    assign lim_neg   = -lim_pos;

    assign adx       = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
    assign ady       = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
    assign sq_x      = SQ_W'(adx) * SQ_W'(adx);
    assign sq_y      = SQ_W'(ady) * SQ_W'(ady);
    assign travel_sq = QW'(sq_x) + QW'(sq_y);

    always_comb begin
        if (sum_yaw > SW'(ANG_MAX)) begin
            o_res.yaw = ANG_MAX;
        end else if (sum_yaw < SW'(ANG_MIN)) begin
            o_res.yaw = ANG_MIN;
        end else begin
            o_res.yaw = sum_yaw[ANG_W-1:0];
        end

        if (sum_pitch > lim_pos) begin
            o_res.pitch = lim_pos[ANG_W-1:0];
        end else if (sum_pitch < lim_neg) begin
            o_res.pitch = lim_neg[ANG_W-1:0];
        end else begin
            o_res.pitch = sum_pitch[ANG_W-1:0];
        end

        o_res.rotate = travel_sq > QW'(i_thr_sq);
    end

endmodule

### sv/drte_ease.sv
`timescale 1ns / 1ps
module drte_ease (
    input  drte_pkg::t_angle             i_cur,
    input  drte_pkg::t_angle             i_tgt,
    input  logic [drte_pkg::ALPHA_W-1:0] i_alpha,
    input  logic [drte_pkg::DB_W-1:0]    i_deadband,
    output drte_pkg::t_angle             o_next
);
    import drte_pkg::*;

    localparam int DIFF_W = ANG_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;
    localparam int STEP_W = PROD_W - EASE_SHIFT;
    localparam int SUM_W  = STEP_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic signed [PROD_W-1:0] prod;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;

    assign diff     = DIFF_W'(i_tgt) - DIFF_W'(i_cur);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, i_alpha}));
    assign step     = prod[PROD_W-1:EASE_SHIFT];
    assign sum      = SUM_W'(i_cur) + SUM_W'(step);

    always_comb begin
        if (diff_abs < DIFF_W'(i_deadband)) begin
            o_next = i_tgt;
        end else if (sum > SUM_W'(ANG_MAX)) begin
            o_next = ANG_MAX;
        end else if (sum < SUM_W'(ANG_MIN)) begin
            o_next = ANG_MIN;
        end else begin
            o_next = sum[ANG_W-1:0];
        end
    end

endmodule

### sv/drag_rotate_easing_tracker_unit.sv
`timescale 1ns / 1ps
// Path: an item is captured in the input register, then its result in the result register,
// from which it transfers when the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; the state update for an
// item completes in the cycle it is processed, so the next item sees it immediately.
// Reset (i_rst_n low, synchronous) restores the configuration defaults, clears all angles,
// the start point and the flags, and empties both pipeline registers.
module drag_rotate_easing_tracker_unit #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [drte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drte_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [drte_pkg::CMD_W-1:0]     i_command,
    input  logic [COORD_BITS-1:0]          i_touch_x,
    input  logic [COORD_BITS-1:0]          i_touch_y,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output drte_pkg::t_angle               o_yaw_now,
    output drte_pkg::t_angle               o_pitch_now,
    output logic                           o_finger_down,
    output logic                           o_at_home,
    output logic                           o_rotate_seen
);
    import drte_pkg::*;

    // Configuration
    logic [ALPHA_W-1:0]  r_alpha;
    logic [SENS_W-1:0]   r_sens;
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic [LIM_W-1:0]    r_pitch_lim;
    logic [DB_W-1:0]     r_deadband;
    logic [SETTLE_W-1:0] r_settle;

    // Tracker state
    t_angle                r_tgt_yaw, r_tgt_pitch, r_cur_yaw, r_cur_pitch;
    t_angle                r_anc_yaw, r_anc_pitch;
    logic [COORD_BITS-1:0] r_start_x, r_start_y;
    logic                  r_active, r_rotate;

    t_angle                n_tgt_yaw, n_tgt_pitch, n_cur_yaw, n_cur_pitch;
    t_angle                n_anc_yaw, n_anc_pitch;
    logic [COORD_BITS-1:0] n_start_x, n_start_y;
    logic                  n_active, n_rotate, n_home;

    // Input register
    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_cmd;
    logic [COORD_BITS-1:0] r_x, r_y;

    // Result register
    logic r_out_valid;

    logic      hold, fire, in_take;
    t_move_res move_res;
    t_angle    ease_yaw, ease_pitch;
    logic [THR_W-1:0] thr_in;

    // A waiting result only blocks the pipe when the downstream side stalls it.
    assign hold       = r_out_valid && i_out_stall;
    assign fire       = r_in_valid && !hold;
    assign o_in_stall = r_in_valid && hold;
    assign in_take    = i_in_valid && !o_in_stall;

    assign thr_in = i_cfg_data[THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= RST_EASE_ALPHA;
            r_sens      <= RST_SENSITIVITY;
            r_thr_sq    <= RST_ROT_THR_SQ;
            r_pitch_lim <= RST_PITCH_LIM;
            r_deadband  <= RST_DEADBAND;
            r_settle    <= RST_SETTLE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EASE_ALPHA:  r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_SENSITIVITY: r_sens      <= i_cfg_data[SENS_W-1:0];
                // The threshold is only ever compared squared, so square it on write.
                CFG_ROT_THR:     r_thr_sq    <= THR_SQ_W'(thr_in) * THR_SQ_W'(thr_in);
                CFG_PITCH_LIM:   r_pitch_lim <= i_cfg_data[LIM_W-1:0];
                CFG_DEADBAND:    r_deadband  <= i_cfg_data[DB_W-1:0];
                CFG_SETTLE:      r_settle    <= i_cfg_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    drte_move #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_move (
        .i_x            (r_x),
        .i_y            (r_y),
        .i_start_x      (r_start_x),
        .i_start_y      (r_start_y),
        .i_anchor_yaw   (r_anc_yaw),
        .i_anchor_pitch (r_anc_pitch),
        .i_sens         (r_sens),
        .i_pitch_lim    (r_pitch_lim),
        .i_thr_sq       (r_thr_sq),
        .o_res          (move_res)
    );

    drte_ease u_ease_yaw (
        .i_cur      (r_cur_yaw),
        .i_tgt      (r_tgt_yaw),
        .i_alpha    (r_alpha),
        .i_deadband (r_deadband),
        .o_next     (ease_yaw)
    );

    drte_ease u_ease_pitch (
        .i_cur      (r_cur_pitch),
        .i_tgt      (r_tgt_pitch),
        .i_alpha    (r_alpha),
        .i_deadband (r_deadband),
        .o_next     (ease_pitch)
    );

    always_comb begin
        n_tgt_yaw   = r_tgt_yaw;
        n_tgt_pitch = r_tgt_pitch;
        n_cur_yaw   = r_cur_yaw;
        n_cur_pitch = r_cur_pitch;
        n_anc_yaw   = r_anc_yaw;
        n_anc_pitch = r_anc_pitch;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_active    = r_active;
        n_rotate    = r_rotate;
        case (r_cmd)
            CMD_BEGIN: begin
                n_active    = 1'b1;
                n_rotate    = 1'b0;
                n_start_x   = r_x;
                n_start_y   = r_y;
                n_anc_yaw   = r_cur_yaw;
                n_anc_pitch = r_cur_pitch;
                n_tgt_yaw   = r_cur_yaw;
                n_tgt_pitch = r_cur_pitch;
            end
            CMD_MOVE: begin
                n_tgt_yaw   = move_res.yaw;
                n_tgt_pitch = move_res.pitch;
                n_rotate    = r_rotate || move_res.rotate;
            end
            CMD_END: begin
                n_active    = 1'b0;
                n_tgt_yaw   = '0;
                n_tgt_pitch = '0;
            end
            CMD_RESET: begin
                n_active    = 1'b0;
                n_rotate    = 1'b0;
                n_cur_yaw   = '0;
                n_cur_pitch = '0;
                n_tgt_yaw   = '0;
                n_tgt_pitch = '0;
            end
            CMD_TICK: begin
                n_cur_yaw   = ease_yaw;
                n_cur_pitch = ease_pitch;
            end
            default: ;
        endcase
        n_home = !n_active
              && (ang_abs(n_cur_yaw) < ANG_W'(r_settle))
              && (ang_abs(n_cur_pitch) < ANG_W'(r_settle));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_yaw   <= '0;
            r_tgt_pitch <= '0;
            r_cur_yaw   <= '0;
            r_cur_pitch <= '0;
            r_anc_yaw   <= '0;
            r_anc_pitch <= '0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_active    <= 1'b0;
            r_rotate    <= 1'b0;
        end else if (fire) begin
            r_tgt_yaw   <= n_tgt_yaw;
            r_tgt_pitch <= n_tgt_pitch;
            r_cur_yaw   <= n_cur_yaw;
            r_cur_pitch <= n_cur_pitch;
            r_anc_yaw   <= n_anc_yaw;
            r_anc_pitch <= n_anc_pitch;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_active    <= n_active;
            r_rotate    <= n_rotate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_command;
            r_x   <= i_touch_x;
            r_y   <= i_touch_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_yaw_now     <= n_cur_yaw;
            o_pitch_now   <= n_cur_pitch;
            o_finger_down <= n_active;
            o_at_home     <= n_home;
            o_rotate_seen <= n_rotate;
        end
    end

    assign o_out_valid = r_out_valid;

    a_home_not_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_at_home && o_finger_down))
        else $error("result reports at home while a drag is active");

    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && hold) |=> r_in_valid)
        else $error("held input item was dropped");

    a_reset_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cmd == CMD_RESET) |=>
            (r_cur_yaw == '0 && r_cur_pitch == '0 && !r_active && !r_rotate))
        else $error("reset command left state behind");

    a_begin_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cmd == CMD_BEGIN) |=>
            (r_active && r_tgt_yaw == r_cur_yaw && r_tgt_pitch == r_cur_pitch))
        else $error("begin did not align target with current angle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed item produced no result");

endmodule
